@@ rtl/efa_pkg.sv @@
// Shared types, codes and constants for the event frame accumulator.
// Used by efa_ctrl, efa_datapath and the top level; depends on nothing.
package efa_pkg;

    localparam int DEF_WIDTH  = 128;
    localparam int DEF_HEIGHT = 128;

    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 3 * CHAN_W;
    localparam int COORD_W = 7;
    localparam int CMD_W   = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FADE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_FADE = 1'b1;

    localparam logic [CHAN_W-1:0] FADE_RESET = 8'd30;
    localparam logic [CHAN_W-1:0] GRAY      = 8'h80;

    localparam logic [PIXEL_W-1:0] COL_BLACK = 24'h000000;
    localparam logic [PIXEL_W-1:0] COL_GREEN = 24'h00FF00;
    localparam logic [PIXEL_W-1:0] COL_RED   = 24'hFF0000;
    localparam logic [PIXEL_W-1:0] COL_WHITE = 24'hFFFFFF;
    localparam logic [PIXEL_W-1:0] COL_GRAY  = 24'h808080;

    // Palette color for polarity 0/1 in the given mode
    function automatic logic [PIXEL_W-1:0] event_color(input logic mode, input logic pol);
        logic [PIXEL_W-1:0] c;
        if (mode)
            c = pol ? COL_BLACK : COL_WHITE;
        else
            c = pol ? COL_RED : COL_GREEN;
        return c;
    endfunction

    function automatic logic [PIXEL_W-1:0] background_color(input logic mode);
        return mode ? COL_GRAY : COL_BLACK;
    endfunction

    // Commands from controller to datapath
    typedef struct packed {
        logic fill_we;   // write fill color at sweep pointer, advance
        logic fill_bg;   // fill with mode background, else black
        logic fade_rd;   // read pixel at sweep pointer for fade, advance
        logic ev_we;     // write event color at (x,y)
        logic rd_req;    // read pixel at (x,y)
        logic out_load;  // load the result register
        logic out_pix;   // result carries the read pixel
        logic out_done;  // done flag of the result
    } efa_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic out_busy;
    } efa_stat_t;

endpackage

@@ rtl/efa_ctrl.sv @@
// Command sequencer for the event frame accumulator: accepts items, runs the
// sweeps and schedules results. Depends on efa_pkg.
module efa_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [efa_pkg::CMD_W-1:0] cmd,
    input  logic                    batch_end,
    input  efa_pkg::efa_stat_t      stat,
    output efa_pkg::efa_cmd_t       ctl
);
    import efa_pkg::*;

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_FADE  = 6'b001000,
        S_FLUSH = 6'b010000,
        S_CLEAR = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE) || stat.out_busy;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_INIT:
            begin
                // sweep the store to black after reset
                ctl.fill_we = 1'b1;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_EVENT:
                        begin
                            ctl.ev_we    = 1'b1;
                            ctl.out_load = 1'b1;
                            ctl.out_done = batch_end;
                        end
                        CMD_FADE:  state_next = S_FADE;
                        CMD_READ:
                        begin
                            ctl.rd_req = 1'b1;
                            state_next = S_READ;
                        end
                        default:   state_next = S_CLEAR;
                    endcase
                end
            end
            S_READ:
            begin
                ctl.out_load = 1'b1;
                ctl.out_pix  = 1'b1;
                ctl.out_done = 1'b1;
                state_next   = S_IDLE;
            end
            S_FADE:
            begin
                ctl.fade_rd = 1'b1;
                if (stat.sweep_last)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                // last fade write lands this cycle
                ctl.out_load = 1'b1;
                ctl.out_done = 1'b1;
                state_next   = S_IDLE;
            end
            S_CLEAR:
            begin
                ctl.fill_we = 1'b1;
                ctl.fill_bg = 1'b1;
                if (stat.sweep_last)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:   state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/efa_datapath.sv @@
// Frame memory, sweep pointer, fade arithmetic, config registers and result
// register of the event frame accumulator. Depends on efa_pkg.
module efa_datapath #(
    parameter int WIDTH  = efa_pkg::DEF_WIDTH,
    parameter int HEIGHT = efa_pkg::DEF_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  efa_pkg::efa_cmd_t           ctl,
    output efa_pkg::efa_stat_t          stat,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [efa_pkg::CHAN_W-1:0]  cfg_data,
    input  logic [efa_pkg::COORD_W-1:0] pix_x,
    input  logic [efa_pkg::COORD_W-1:0] pix_y,
    input  logic                        polarity,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [efa_pkg::CHAN_W-1:0]  red,
    output logic [efa_pkg::CHAN_W-1:0]  green,
    output logic [efa_pkg::CHAN_W-1:0]  blue,
    output logic                        done_res
);
    import efa_pkg::*;

    localparam int NPIX  = WIDTH * HEIGHT;
    localparam int AW    = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int IDX_W = 22;

    logic [PIXEL_W-1:0] frame_mem [NPIX];

    logic               mode_reg;
    logic [CHAN_W-1:0]  fade_reg;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [PIXEL_W-1:0] rd_data_reg;
    logic               in_frame_reg;
    logic               fade_wr_reg;
    logic [AW-1:0]      fade_addr_reg;
    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] pix_reg;
    logic               done_reg;

    logic [IDX_W-1:0]   idx_wide;
    logic [AW-1:0]      idx;
    logic               in_frame;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [PIXEL_W-1:0] wdata;
    logic [PIXEL_W-1:0] fade_pix;
    logic               fade_we;

    logic [CHAN_W-1:0]  r_in, g_in, b_in, r_dec, g_dec;
    logic [CHAN_W-2:0]  step;
    logic [CHAN_W:0]    sum9, floor9;
    logic [CHAN_W-1:0]  v_up, v_down, v;

    assign idx_wide = IDX_W'(pix_y) * IDX_W'(WIDTH) + IDX_W'(pix_x);
    assign idx      = idx_wide[AW-1:0];
    assign in_frame = (IDX_W'(pix_x) < IDX_W'(WIDTH)) && (IDX_W'(pix_y) < IDX_W'(HEIGHT));

    assign stat.sweep_last = (ptr_reg == AW'(NPIX - 1));
    assign stat.out_busy   = out_valid_reg && out_stall;

    // sweep pointer wraps so it rests at zero between sweeps
    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctl.fill_we || ctl.fade_rd)
            ptr_next = stat.sweep_last ? '0 : ptr_reg + AW'(1);
    end

    assign rd_en   = ctl.rd_req || ctl.fade_rd;
    assign rd_addr = ctl.rd_req ? idx : ptr_reg;

    // fade arithmetic on the pixel read last cycle
    assign r_in  = rd_data_reg[PIXEL_W-1 -: CHAN_W];
    assign g_in  = rd_data_reg[CHAN_W +: CHAN_W];
    assign b_in  = rd_data_reg[CHAN_W-1:0];
    assign r_dec = (r_in > fade_reg) ? r_in - fade_reg : '0;
    assign g_dec = (g_in > fade_reg) ? g_in - fade_reg : '0;
    assign step  = fade_reg[CHAN_W-1:1];

    assign sum9   = {1'b0, b_in} + {2'b00, step};
    assign floor9 = {1'b0, GRAY} + {2'b00, step};
    assign v_up   = (sum9 > {1'b0, GRAY}) ? GRAY : sum9[CHAN_W-1:0];
    assign v_down = ({1'b0, b_in} >= floor9) ? b_in - {1'b0, step} : GRAY;
    assign v      = (b_in < GRAY) ? v_up : v_down;

    assign fade_pix = mode_reg ? {v, v, v} : {r_dec, g_dec, b_in};
    // gray-mode fade leaves pixels with blue at gray untouched
    assign fade_we  = fade_wr_reg && !(mode_reg && (b_in == GRAY));

    always_comb
    begin
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = COL_BLACK;
        if (ctl.fill_we)
        begin
            we    = 1'b1;
            wdata = ctl.fill_bg ? background_color(mode_reg) : COL_BLACK;
        end
        else if (fade_we)
        begin
            we    = 1'b1;
            waddr = fade_addr_reg;
            wdata = fade_pix;
        end
        else if (ctl.ev_we && in_frame)
        begin
            we    = 1'b1;
            waddr = idx;
            wdata = event_color(mode_reg, polarity);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            frame_mem[waddr] <= wdata;
        if (rd_en)
            rd_data_reg <= frame_mem[rd_addr];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            fade_reg      <= FADE_RESET;
            ptr_reg       <= '0;
            fade_wr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_data[0];
                    CFG_FADE: fade_reg <= cfg_data;
                    default:  fade_reg <= fade_reg;
                endcase
            end
            ptr_reg       <= ptr_next;
            fade_wr_reg   <= ctl.fade_rd;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fade_addr_reg <= ptr_reg;
        if (ctl.rd_req)
            in_frame_reg <= in_frame;
        if (ctl.out_load)
        begin
            pix_reg  <= (ctl.out_pix && in_frame_reg) ? rd_data_reg : COL_BLACK;
            done_reg <= ctl.out_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = pix_reg[PIXEL_W-1 -: CHAN_W];
    assign green     = pix_reg[CHAN_W +: CHAN_W];
    assign blue      = pix_reg[CHAN_W-1:0];
    assign done_res  = done_reg;

endmodule

@@ rtl/event_frame_accumulator_with_fade.sv @@
// Top level of the event frame accumulator: sequencer plus datapath.
// Depends on efa_pkg, efa_ctrl and efa_datapath.
//
// A WIDTH x HEIGHT RGB frame store painted by camera events, faded and cleared
// by full sweeps, and read one pixel at a time; every command returns one
// result beat. Sweeps move one pixel a cycle through the single write port of
// the frame memory, and a fade places a registered read ahead of each write.
// After reset the block first sweeps the store to black with in_stall high;
// configuration writes are taken at any time and cfg_ready is always high.
// in_stall stays high while a finished result is held up by out_stall; the next
// item is taken on the same edge that the waiting result beat leaves.
module event_frame_accumulator_with_fade #(
    parameter int WIDTH  = efa_pkg::DEF_WIDTH,
    parameter int HEIGHT = efa_pkg::DEF_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [efa_pkg::CMD_W-1:0]     cmd,
    input  logic [efa_pkg::COORD_W-1:0]   pix_x,
    input  logic [efa_pkg::COORD_W-1:0]   pix_y,
    input  logic                          polarity,
    input  logic                          batch_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [efa_pkg::CHAN_W-1:0]    red,
    output logic [efa_pkg::CHAN_W-1:0]    green,
    output logic [efa_pkg::CHAN_W-1:0]    blue,
    output logic                          done_res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [efa_pkg::CHAN_W-1:0]    cfg_data
);
    import efa_pkg::*;

    efa_cmd_t  ctl;
    efa_stat_t stat;

    assign cfg_ready = 1'b1;

    efa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .batch_end (batch_end),
        .stat      (stat),
        .ctl       (ctl)
    );

    efa_datapath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .polarity  (polarity),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .done_res  (done_res)
    );

    // Never take an item while a result beat is held up downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !(out_valid && out_stall))
        else $error("item accepted while result register blocked");

    // Memory port users are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.fill_we, ctl.fade_rd, ctl.ev_we, ctl.rd_req}))
        else $error("conflicting frame memory commands");

    // An event answers on the next cycle with its batch flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && cmd == CMD_EVENT)
        |=> (out_valid && done_res == $past(batch_end)))
        else $error("event result missing or wrong done flag");

    // A read answers once S_READ has loaded the read pixel into the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && cmd == CMD_READ) |-> ##2 (out_valid && done_res))
        else $error("read result missing");

endmodule
